FILE: rtl/core/gf2irr_pkg.sv
// shared types and constants of the gf2 polynomial irreducibility tester
`default_nettype none
package gf2irr_pkg;

	localparam int COEF_W     = 63;
	localparam int DEG_W      = 6;
	localparam int POLY_W     = 64;
	localparam int ROUND_W    = 5;
	localparam int MIN_DEGREE = 3;
	localparam int MAX_DEGREE = 63;

	typedef struct packed {
		logic [COEF_W-1:0] coefficients;
		logic [DEG_W-1:0]  degree;
	} gf2irr_in_t;

	typedef struct packed {
		logic [POLY_W-1:0] polynomial;
		logic              irreducible;
	} gf2irr_out_t;

	// shift-xor unit operation
	typedef struct packed {
		logic shl;
		logic red;
		logic add;
	} gf2irr_op_t;

	typedef struct packed {
		logic start;
		logic take;
	} gf2irr_ctrl_t;

	typedef struct packed {
		logic idle;
		logic done;
		logic irred;
	} gf2irr_stat_t;

endpackage
`default_nettype wire

FILE: rtl/core/gf2irr_alu.sv
// shared shift-xor unit: optional left shift, modular fold, conditional add
`default_nettype none
module gf2irr_alu (
	input  wire gf2irr_pkg::gf2irr_op_t        op,
	input  wire [gf2irr_pkg::POLY_W-1:0]       opa,
	input  wire [gf2irr_pkg::POLY_W-1:0]       fold,
	input  wire [gf2irr_pkg::POLY_W-1:0]       addend,
	output logic [gf2irr_pkg::POLY_W-1:0]      res
);
	import gf2irr_pkg::*;

	logic [POLY_W-1:0] t;

	always_comb begin
		t = op.shl ? {opa[POLY_W-2:0], 1'b0} : opa;
		// operands are left-justified, so the modulus leading term sits at the top bit
		if (op.red && t[POLY_W-1]) begin
			t = t ^ fold;
		end
		if (op.add) begin
			t = t ^ addend;
		end
		res = t;
	end

endmodule
`default_nettype wire

FILE: rtl/core/gf2irr_engine.sv
// sequencer for the squaring and gcd rounds over the shared shift-xor unit
`default_nettype none
module gf2irr_engine (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire gf2irr_pkg::gf2irr_ctrl_t     ctrl,
	input  wire [gf2irr_pkg::POLY_W-1:0]      pj,
	input  wire [gf2irr_pkg::POLY_W-1:0]      xj,
	input  wire [gf2irr_pkg::DEG_W-1:0]       deg,
	output gf2irr_pkg::gf2irr_stat_t          stat
);
	import gf2irr_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SQR  = 2'd1;
	localparam logic [1:0] ST_GCD  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]         state_q;
	logic [DEG_W-1:0]   k_q;
	logic [ROUND_W-1:0] rnd_q;
	logic               irred_q;

	logic [POLY_W-1:0]  pj_q;
	logic [POLY_W-1:0]  xj_q;
	logic [POLY_W-1:0]  r_q;
	logic [POLY_W-1:0]  a_q;
	logic [POLY_W-1:0]  b_q;
	logic [DEG_W-1:0]   d_q;
	logic [DEG_W-1:0]   da_q;
	logic [DEG_W-1:0]   db_q;

	gf2irr_op_t         alu_op;
	logic [POLY_W-1:0]  alu_in;
	logic [POLY_W-1:0]  alu_add;
	logic [POLY_W-1:0]  alu_out;
	logic               alu_sel_b;
	logic               a_nz;
	logic               b_nz;
	logic               a_norm;
	logic               b_norm;
	logic               fin;
	logic               cop;
	logic               sqr_last;

	gf2irr_alu u_alu (
		.op     (alu_op),
		.opa    (alu_in),
		.fold   (pj_q),
		.addend (alu_add),
		.res    (alu_out)
	);

	always_comb begin
		a_nz      = |a_q;
		b_nz      = |b_q;
		a_norm    = !a_nz || a_q[POLY_W-1];
		b_norm    = !b_nz || b_q[POLY_W-1];
		fin       = a_norm && b_norm && (!a_nz || !b_nz);
		cop       = !a_nz ? (db_q == '0) : (da_q == '0);
		sqr_last  = (k_q == DEG_W'(1));
		alu_op    = '0;
		alu_in    = a_q;
		alu_add   = b_q;
		alu_sel_b = 1'b0;
		case (state_q)
			ST_SQR: begin
				// one bit of the multiplier per cycle, top bit first
				alu_op.shl = 1'b1;
				alu_op.red = 1'b1;
				alu_op.add = b_q[POLY_W-2];
				alu_add    = r_q;
			end
			ST_GCD: begin
				if (!a_norm) begin
					alu_op.shl = 1'b1;
				end else if (!b_norm) begin
					alu_op.shl = 1'b1;
					alu_in     = b_q;
					alu_sel_b  = 1'b1;
				end else if (a_nz && b_nz) begin
					alu_op.add = 1'b1;
					if (da_q < db_q) begin
						alu_in    = b_q;
						alu_add   = a_q;
						alu_sel_b = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			rnd_q   <= '0;
			irred_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (ctrl.start) begin
						state_q <= ST_SQR;
						k_q     <= deg;
						rnd_q   <= deg[DEG_W-1:1];
					end
				end
				ST_SQR: begin
					k_q <= k_q - DEG_W'(1);
					if (sqr_last) begin
						state_q <= ST_GCD;
					end
				end
				ST_GCD: begin
					if (fin) begin
						if (!cop) begin
							irred_q <= 1'b0;
							state_q <= ST_DONE;
						end else if (rnd_q == ROUND_W'(1)) begin
							irred_q <= 1'b1;
							state_q <= ST_DONE;
						end else begin
							rnd_q   <= rnd_q - ROUND_W'(1);
							k_q     <= d_q;
							state_q <= ST_SQR;
						end
					end
				end
				ST_DONE: begin
					if (ctrl.take) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (ctrl.start) begin
					pj_q <= pj;
					xj_q <= xj;
					d_q  <= deg;
					r_q  <= xj;
					a_q  <= '0;
					b_q  <= xj;
				end
			end
			ST_SQR: begin
				if (sqr_last) begin
					r_q  <= alu_out;
					a_q  <= pj_q;
					b_q  <= alu_out ^ xj_q;
					da_q <= d_q;
					db_q <= d_q;
				end else begin
					a_q <= alu_out;
					b_q <= {b_q[POLY_W-2:0], 1'b0};
				end
			end
			ST_GCD: begin
				if (fin) begin
					// next round restarts the square of r
					a_q <= '0;
					b_q <= r_q;
				end else if (alu_sel_b) begin
					b_q <= alu_out;
					if (alu_op.shl) begin
						db_q <= db_q - DEG_W'(1);
					end
				end else begin
					a_q <= alu_out;
					if (alu_op.shl) begin
						da_q <= da_q - DEG_W'(1);
					end
				end
			end
			default: ;
		endcase
	end

	assign stat.idle  = (state_q == ST_IDLE);
	assign stat.done  = (state_q == ST_DONE);
	assign stat.irred = irred_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.start |-> state_q == ST_IDLE)
		else $error("start seen while engine busy");

	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !ctrl.take) |=> state_q == ST_DONE)
		else $error("result dropped before it was taken");

	a_sqr_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SQR || state_q == ST_GCD) |-> (k_q != '0 || state_q == ST_GCD)
			&& rnd_q != '0)
		else $error("round or step counter ran out");

	a_gcd_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_GCD |-> (a_q != '0 || b_q != '0))
		else $error("both gcd operands zero");

endmodule
`default_nettype wire

FILE: rtl/core/gf2_poly_irreducibility_test.sv
// top level of the gf2 polynomial irreducibility tester
// Ben-Or irreducibility test over GF(2). Each item beat carries candidate
// coefficient bits and a degree d; d below 3 is raised to 3, bits at or above
// d are cleared and bit d is set. One item is worked at a time: item_ready is
// high only while the engine is idle. For each round i = 1..floor(d/2) the
// engine squares x^(2^(i-1)) mod p, one multiplier bit per cycle, then runs
// a shift-xor gcd and checks its outcome, all on one shared shift-xor unit. A
// round whose gcd is not 1 ends the item at once. The result register lets the
// next item be accepted while a finished result beat still waits to be taken.
`default_nettype none
module gf2_poly_irreducibility_test (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         item_valid,
	output logic                        item_ready,
	input  wire gf2irr_pkg::gf2irr_in_t item,
	output logic                        result_valid,
	input  wire                         result_ready,
	output gf2irr_pkg::gf2irr_out_t     result
);
	import gf2irr_pkg::*;

	gf2irr_ctrl_t      ctrl;
	gf2irr_stat_t      stat;
	logic [DEG_W-1:0]  deg_n;
	logic [POLY_W-1:0] p_n;
	logic [POLY_W-1:0] pj_n;
	logic [POLY_W-1:0] xj_n;
	logic [POLY_W-1:0] p_q;

	always_comb begin
		deg_n = (item.degree < DEG_W'(MIN_DEGREE)) ? DEG_W'(MIN_DEGREE) : item.degree;
		p_n   = ({1'b0, item.coefficients} & ~({POLY_W{1'b1}} << deg_n))
			| (POLY_W'(1) << deg_n);
		// left-justified copies: leading term of p at the top bit, x scaled alike
		pj_n  = p_n << (DEG_W'(MAX_DEGREE) - deg_n);
		xj_n  = POLY_W'(1) << (7'(POLY_W) - {1'b0, deg_n});
	end

	assign item_ready = stat.idle;
	assign ctrl.start = item_valid && item_ready;
	assign ctrl.take  = stat.done && (!result_valid || result_ready);

	gf2irr_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.pj     (pj_n),
		.xj     (xj_n),
		.deg    (deg_n),
		.stat   (stat)
	);

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			p_q <= p_n;
		end
		if (ctrl.take) begin
			result.polynomial  <= p_q;
			result.irreducible <= stat.irred;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (ctrl.take) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

endmodule
`default_nettype wire
